FILE: sv/dlr_pkg.sv
package dlr_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_start;
      logic div_step;
      logic emit_first;
      logic advance;
   } dlr_cmd_type;

   typedef struct packed {
      logic active;
      logic len_zero;
   } dlr_sts_type;

endpackage

FILE: sv/dlr_div.sv
module dlr_div #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  start,
   input  logic                  step,
   input  logic [COORD_BITS-1:0] dividend,
   input  logic [COORD_BITS-1:0] divisor,
   output logic [FRAC_BITS:0]    quotient
);
   import dlr_pkg::*;

   logic [COORD_BITS:0] rem_ff, rem_in;
   logic [FRAC_BITS:0]  quo_ff, quo_in;
   logic [COORD_BITS:0] div_ext;
   logic [COORD_BITS:0] diff;
   logic [COORD_BITS:0] base;
   logic                ge;

   // restoring division of dividend * 2^FRAC_BITS, one quotient bit per step
   always_comb begin
      div_ext = {1'b0, divisor};
      ge      = (rem_ff >= div_ext);
      diff    = rem_ff - div_ext;
      base    = ge ? diff : rem_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         rem_in = {1'b0, dividend};
         quo_in = '0;
      end else if (step) begin
         rem_in = {base[COORD_BITS-1:0], 1'b0};
         quo_in = {quo_ff[FRAC_BITS-1:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

FILE: sv/dlr_datapath.sv
module dlr_datapath #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dlr_pkg::dlr_cmd_type         cmd,
   output dlr_pkg::dlr_sts_type         sts,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic signed [COORD_BITS-1:0] pixel_x,
   output logic signed [COORD_BITS-1:0] pixel_y,
   output logic                         last
);
   import dlr_pkg::*;

   localparam int PosBits  = COORD_BITS + FRAC_BITS;
   localparam int StepBits = FRAC_BITS + 2;

   logic signed [PosBits-1:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [StepBits-1:0]   step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [COORD_BITS-1:0]        left_ff, left_in;
   logic                         active_ff, active_in;
   logic [COORD_BITS:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [COORD_BITS-1:0]        mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [COORD_BITS-1:0]        len_ff, len_in;
   logic                         neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic signed [COORD_BITS-1:0] pixel_x_ff, pixel_x_in, pixel_y_ff, pixel_y_in;
   logic                         last_ff, last_in;

   logic [COORD_BITS:0]          abs_x, abs_y;
   logic [FRAC_BITS:0]           quo_x, quo_y;
   logic [StepBits-1:0]          uq_x, uq_y;
   logic signed [PosBits-1:0]    sum_x, sum_y;
   logic signed [PosBits-1:0]    src_x, src_y;
   logic [PosBits-1:0]           bias_x, bias_y;
   logic [PosBits-1:0]           trunc_x, trunc_y;

   dlr_div #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div_x (
      .clock   (clock),
      .start   (cmd.div_start),
      .step    (cmd.div_step),
      .dividend(mag_x_ff),
      .divisor (len_ff),
      .quotient(quo_x)
   );

   dlr_div #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div_y (
      .clock   (clock),
      .start   (cmd.div_start),
      .step    (cmd.div_step),
      .dividend(mag_y_ff),
      .divisor (len_ff),
      .quotient(quo_y)
   );

   always_comb begin
      abs_x = dx_ff[COORD_BITS] ? (~dx_ff + 1'b1) : dx_ff;
      abs_y = dy_ff[COORD_BITS] ? (~dy_ff + 1'b1) : dy_ff;
      uq_x  = {1'b0, quo_x};
      uq_y  = {1'b0, quo_y};

      sum_x = pos_x_ff + {{(PosBits-StepBits){step_x_ff[StepBits-1]}}, step_x_ff};
      sum_y = pos_y_ff + {{(PosBits-StepBits){step_y_ff[StepBits-1]}}, step_y_ff};
      src_x = cmd.advance ? sum_x : pos_x_ff;
      src_y = cmd.advance ? sum_y : pos_y_ff;

      // truncate toward zero: bias negative positions before the shift
      bias_x  = src_x[PosBits-1] ? {{COORD_BITS{1'b0}}, {FRAC_BITS{1'b1}}} : '0;
      bias_y  = src_y[PosBits-1] ? {{COORD_BITS{1'b0}}, {FRAC_BITS{1'b1}}} : '0;
      trunc_x = src_x + bias_x;
      trunc_y = src_y + bias_y;

      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      step_x_in  = step_x_ff;
      step_y_in  = step_y_ff;
      left_in    = left_ff;
      active_in  = active_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      mag_x_in   = mag_x_ff;
      mag_y_in   = mag_y_ff;
      len_in     = len_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      pixel_x_in = pixel_x_ff;
      pixel_y_in = pixel_y_ff;
      last_in    = last_ff;

      if (cmd.load) begin
         pos_x_in  = {start_x, {FRAC_BITS{1'b0}}};
         pos_y_in  = {start_y, {FRAC_BITS{1'b0}}};
         dx_in     = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
         dy_in     = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
         active_in = 1'b0;
      end

      if (cmd.prep) begin
         neg_x_in = dx_ff[COORD_BITS];
         neg_y_in = dy_ff[COORD_BITS];
         mag_x_in = abs_x[COORD_BITS-1:0];
         mag_y_in = abs_y[COORD_BITS-1:0];
         len_in   = (abs_x[COORD_BITS-1:0] >= abs_y[COORD_BITS-1:0]) ?
                    abs_x[COORD_BITS-1:0] : abs_y[COORD_BITS-1:0];
      end

      if (cmd.div_start) begin
         left_in = len_ff;
      end

      if (cmd.emit_first) begin
         if (len_ff == '0) begin
            step_x_in = '0;
            step_y_in = '0;
         end else begin
            step_x_in = neg_x_ff ? -uq_x : uq_x;
            step_y_in = neg_y_ff ? -uq_y : uq_y;
         end
         active_in  = (len_ff != '0);
         pixel_x_in = trunc_x[PosBits-1:FRAC_BITS];
         pixel_y_in = trunc_y[PosBits-1:FRAC_BITS];
         last_in    = (len_ff == '0);
      end

      if (cmd.advance) begin
         pos_x_in   = sum_x;
         pos_y_in   = sum_y;
         left_in    = left_ff - 1'b1;
         active_in  = (left_ff != {{(COORD_BITS-1){1'b0}}, 1'b1});
         pixel_x_in = trunc_x[PosBits-1:FRAC_BITS];
         pixel_y_in = trunc_y[PosBits-1:FRAC_BITS];
         last_in    = (left_ff == {{(COORD_BITS-1){1'b0}}, 1'b1});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         step_x_ff <= '0;
         step_y_ff <= '0;
         left_ff   <= '0;
      end else begin
         active_ff <= active_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         left_ff   <= left_in;
      end
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      mag_x_ff   <= mag_x_in;
      mag_y_ff   <= mag_y_in;
      len_ff     <= len_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      last_ff    <= last_in;
   end

   assign sts.active   = active_ff;
   assign sts.len_zero = (len_ff == '0);
   assign pixel_x      = pixel_x_ff;
   assign pixel_y      = pixel_y_ff;
   assign last         = last_ff;

endmodule

FILE: sv/dlr_ctrl.sv
module dlr_ctrl #(
   parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dlr_pkg::dlr_cmd_type cmd,
   input  dlr_pkg::dlr_sts_type sts
);
   import dlr_pkg::*;

   localparam int CntBits = $clog2(FRAC_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SETUP,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               accept;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_IDLE) && out_free;
      accept    = req_valid && req_ready;

      cmd            = '0;
      cmd.load       = accept && (req_op == OP_LOAD);
      cmd.advance    = accept && (req_op == OP_NEXT) && sts.active;
      cmd.prep       = (state_ff == ST_PREP);
      cmd.div_start  = (state_ff == ST_SETUP);
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.emit_first = (state_ff == ST_EMIT) && out_free;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cnt_in   = '0;
            state_in = sts.len_zero ? ST_EMIT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(FRAC_BITS)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_first || cmd.advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/dda_line_rasterizer.sv
// DDA line rasterizer. A load transaction (op 0) takes a segment's two
// endpoints and, after a prepare, a setup and a divide state (a zero-length
// segment skips the divide), returns its first pixel; two restoring dividers
// working in parallel form the signed per-step increments one quotient bit
// per cycle. Each next-pixel transaction (op 1) then returns the next pixel,
// the 16.16 position truncated toward zero, with last set on the final one of
// the segment's length + 1 pixels; a next-pixel transaction with no segment
// running is accepted and returns nothing. A new transaction is taken when
// the controller is idle and the result register is empty or is being read
// in the same cycle.
module dda_line_rasterizer #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last
);
   import dlr_pkg::*;

   dlr_cmd_type cmd;
   dlr_sts_type sts;

   dlr_ctrl #(
      .FRAC_BITS(FRAC_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op   (req_op),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   dlr_datapath #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .start_x(req_start_x),
      .start_y(req_start_y),
      .end_x  (req_end_x),
      .end_y  (req_end_y),
      .pixel_x(rsp_pixel_x),
      .pixel_y(rsp_pixel_y),
      .last   (rsp_last)
   );

endmodule

FILE: dv/tb_dda_line_rasterizer.sv
module tb_dda_line_rasterizer;
   import dlr_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int PW = CB + FB + 2;
   localparam int STALL_LIMIT = 3000;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic                 last;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_op = OP_NEXT;
   logic signed [CB-1:0] req_start_x = '0;
   logic signed [CB-1:0] req_start_y = '0;
   logic signed [CB-1:0] req_end_x = '0;
   logic signed [CB-1:0] req_end_y = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [CB-1:0] rsp_pixel_x;
   logic signed [CB-1:0] rsp_pixel_y;
   logic                 rsp_last;

   // line state mirrored by the checker
   logic signed [PW-1:0] pos_x, pos_y;
   logic signed [FB+1:0] step_x, step_y;
   logic [CB:0]          pixels_left;
   logic                 seg_active;

   pixel_type pixel_q[$];
   int     mismatches = 0;
   int     items_used = 0;
   int     quiet_cycles = 0;
   bit     steady = 1'b0;

   dda_line_rasterizer #(
      .COORD_BITS(CB),
      .FRAC_BITS (FB)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x  (req_end_x),
      .req_end_y  (req_end_y),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_last   (rsp_last)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 31);
   end

   function automatic logic signed [FB+1:0] step_of(input logic signed [CB:0] d,
                                                    input logic [CB:0] len);
      logic [CB:0]    mag;
      logic [CB+FB:0] num;
      logic [CB+FB:0] q;
      mag = (d < 0) ? -d : d;
      num = mag;
      num = num << FB;
      q = num / len;
      return (d < 0) ? -q[FB+1:0] : q[FB+1:0];
   endfunction

   function automatic logic signed [CB-1:0] pixel_of(input logic signed [PW-1:0] p);
      logic [PW-1:0] mag;
      mag = (p < 0) ? -p : p;
      mag = mag >> FB;
      return (p < 0) ? -mag[CB-1:0] : mag[CB-1:0];
   endfunction

   task automatic rasterize_step(input logic op,
                                 input logic signed [CB-1:0] sx, sy, ex, ey);
      logic signed [CB:0] dx, dy;
      logic [CB:0]        ax, ay, len;
      pixel_type          p;
      if (op == OP_LOAD) begin
         dx = ex - sx;
         dy = ey - sy;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         len = (ax > ay) ? ax : ay;
         pos_x = sx;
         pos_y = sy;
         pos_x = pos_x <<< FB;
         pos_y = pos_y <<< FB;
         step_x = (len == 0) ? '0 : step_of(dx, len);
         step_y = (len == 0) ? '0 : step_of(dy, len);
         pixels_left = len;
         seg_active = (len != 0);
      end else if (seg_active) begin
         pos_x = pos_x + step_x;
         pos_y = pos_y + step_y;
         pixels_left = pixels_left - 1'b1;
         seg_active = (pixels_left != 0);
      end else begin
         return;
      end
      items_used++;
      p.x = pixel_of(pos_x);
      p.y = pixel_of(pos_y);
      p.last = (pixels_left == 0);
      pixel_q.push_back(p);
   endtask

   // results are checked before new transactions are predicted
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_pixel_x, rsp_pixel_y, rsp_last};
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                        $time, got.x, got.y, got.last);
               mismatches++;
            end else begin
               want = pixel_q.pop_front();
               if (got !== want) begin
                  $display("%0t: pixel expected x=%0d y=%0d last=%0b, actual x=%0d y=%0d last=%0b",
                           $time, want.x, want.y, want.last, got.x, got.y, got.last);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            rasterize_step(req_op, req_start_x, req_start_y, req_end_x, req_end_y);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("dda_line_rasterizer: mismatch");
            $finish;
         end
      end
   end

   task automatic send_item(input logic op, input logic signed [CB-1:0] sx, sy, ex, ey);
      @(negedge clock);
      if (!steady) begin
         while ($urandom_range(99) < 31) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic send_next();
      send_item(OP_NEXT, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic int pick_coord();
      case ($urandom_range(9))
         0:       return -(1 << (CB - 1));
         1:       return (1 << (CB - 1)) - 1;
         default: return $signed(CB'($urandom));
      endcase
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < -(1 << (CB - 1)))
         return -(1 << (CB - 1));
      if (v > (1 << (CB - 1)) - 1)
         return (1 << (CB - 1)) - 1;
      return v;
   endfunction

   task automatic test_next_without_segment();
      send_next();
      send_next();
   endtask

   task automatic test_zero_length();
      send_item(OP_LOAD, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_item(OP_LOAD, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_item(OP_LOAD, 16'sd0, -16'sd1, 16'sd0, -16'sd1);
      send_next();
   endtask

   task automatic test_full_span_abandoned();
      send_item(OP_LOAD, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
      repeat (3) send_next();
      send_item(OP_LOAD, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
      repeat (3) send_next();
   endtask

   task automatic test_short_runs();
      send_item(OP_LOAD, -16'sd32768, 16'sd32767, -16'sd32763, 16'sd32765);
      repeat (6) send_next();
      send_item(OP_LOAD, 16'sd10, 16'sd32767, 16'sd9, 16'sd32763);
      repeat (4) send_next();
   endtask

   task automatic test_pause_until_done();
      send_item(OP_LOAD, 16'sd3, -16'sd2, -16'sd4, 16'sd1);
      repeat (2) send_next();
      drain();
      repeat (5) send_next();
      drain();
   endtask

   task automatic test_random_segments(input int n_items);
      int goal, kind, span, sx, sy, ex, ey, run, len;
      goal = items_used + n_items;
      while (items_used < goal) begin
         kind = $urandom_range(99);
         sx = pick_coord();
         sy = pick_coord();
         if (kind < 8) begin
            ex = pick_coord();
            ey = pick_coord();
            run = $urandom_range(8);
         end else begin
            span = (kind < 18) ? 100 : 24;
            ex = clamp_coord(sx + int'($urandom_range(2 * span)) - span);
            ey = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
            len = (ex > sx) ? ex - sx : sx - ex;
            run = (ey > sy) ? ey - sy : sy - ey;
            if (len > run)
               run = len;
            if ($urandom_range(99) < 15)
               run = $urandom_range(run);
         end
         send_item(OP_LOAD, CB'(sx), CB'(sy), CB'(ex), CB'(ey));
         repeat (run) send_next();
         if ($urandom_range(99) < 20)
            repeat ($urandom_range(3, 1)) send_next();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_next_without_segment();
      test_zero_length();
      test_full_span_abandoned();
      test_short_runs();
      test_pause_until_done();
      test_random_segments(900);
      steady = 1'b1;
      test_random_segments(450);
      steady = 1'b0;
      test_random_segments(350);

      drain();
      repeat (FB + 20) @(posedge clock);
      if (mismatches == 0 && pixel_q.size() == 0)
         $display("dda_line_rasterizer: match");
      else
         $display("dda_line_rasterizer: mismatch");
      $finish;
   end

endmodule
